[sv/set_assoc_lru_tag_store_unit_macros.svh]
`ifndef SET_ASSOC_LRU_TAG_STORE_UNIT_MACROS_SVH
`define SET_ASSOC_LRU_TAG_STORE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SALS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tag store assertion failed");

// Next-cycle implication, disabled while reset is active.
`define SALS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tag store assertion failed");

`endif

[sv/sals_pkg.sv]
package sals_pkg;

    localparam int SETS_DEF       = 64;
    localparam int WAYS_DEF       = 8;
    localparam int LINE_BYTES_DEF = 64;
    localparam int ADDR_BITS_DEF  = 48;

    localparam int IN_ADDR_W = 48;
    localparam int OUT_WAY_W = 3;

    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_INVAL  = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [IN_ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic                 forward_miss;
        logic [OUT_WAY_W-1:0] way;
        logic                 replaced;
    } t_rsp;

endpackage

[sv/set_assoc_lru_tag_store_unit.sv]
// Set-associative tag store with true LRU replacement.
// Request: drive i_req (kind, address) with start high; it is taken at a
// rising edge where busy is low. kind selects an access (lookup and fill)
// or an invalidate of the matching line.
// Response: o_strobe is high for exactly one cycle, set from the S_LOOK
// state that follows the request edge, with o_rsp (hit, forward_miss, way,
// replaced). The receiver cannot stall; the response is gone after that
// cycle. The set row is read from the tag and recency RAMs at the request
// edge and the updated row is written back at the next edge, while busy
// holds off the next request, so a read never meets a pending write. A
// new request may be taken at the edge that takes the response.
// SETS and LINE_BYTES are powers of two.
// Reset: busy stays high for SETS cycles after reset is released while a
// clearing pass zeroes the valid bits and ranks one set per cycle. The
// tag RAM is not cleared; a tag is only compared when its way is valid.
`include "set_assoc_lru_tag_store_unit_macros.svh"

module set_assoc_lru_tag_store_unit #(
    parameter int SETS       = sals_pkg::SETS_DEF,
    parameter int WAYS       = sals_pkg::WAYS_DEF,
    parameter int LINE_BYTES = sals_pkg::LINE_BYTES_DEF,
    parameter int ADDR_BITS  = sals_pkg::ADDR_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  sals_pkg::t_req i_req,
    output logic           busy,
    output logic           o_strobe,
    output sals_pkg::t_rsp o_rsp
);
    import sals_pkg::*;

    localparam int SET_W  = $clog2(SETS);
    localparam int IDX_W  = (SET_W > 0) ? SET_W : 1;
    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int EFF_AB = (ADDR_BITS < IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;
    localparam int TAG_RAW = EFF_AB - OFF_W - SET_W;
    localparam int TAG_W  = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int META_W = WAYS * (1 + RANK_W);
    localparam logic [IN_ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= IN_ADDR_W) ? {IN_ADDR_W{1'b1}}
                                 : IN_ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [IDX_W-1:0] SET_MASK = IDX_W'(SETS - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK} t_state;

    t_state              r_state;
    logic                r_busy;
    logic                r_strobe;
    t_rsp                r_rsp;
    logic [IDX_W-1:0]    r_clr_idx;
    logic                r_kind;
    logic [IDX_W-1:0]    r_set;
    logic [TAG_W-1:0]    r_tag;

    logic                accept;
    logic [IN_ADDR_W-1:0] line;
    logic [IDX_W-1:0]    in_set;
    logic [TAG_W-1:0]    in_tag;
    logic [WAYS*TAG_W-1:0] tag_rd, tag_wr;
    logic [META_W-1:0]   meta_rd, meta_upd, meta_wr;
    logic                tag_upd_we;
    logic                tag_we, meta_we;
    logic [IDX_W-1:0]    meta_waddr;
    t_rsp                upd_rsp;

    assign accept = start && !r_busy;
    assign line   = (i_req.address & ADDR_MASK) >> OFF_W;
    assign in_set = IDX_W'(line) & SET_MASK;
    assign in_tag = TAG_W'(line >> SET_W);

    assign tag_we     = (r_state == S_LOOK) && tag_upd_we;
    assign meta_we    = (r_state == S_LOOK) || (r_state == S_CLEAR);
    assign meta_waddr = (r_state == S_CLEAR) ? r_clr_idx : r_set;
    assign meta_wr    = (r_state == S_CLEAR) ? '0 : meta_upd;

    sals_ram #(
        .WIDTH (WAYS * TAG_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_set),
        .i_wdata (tag_wr),
        .i_re    (accept),
        .i_raddr (in_set),
        .o_rdata (tag_rd)
    );

    sals_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wr),
        .i_re    (accept),
        .i_raddr (in_set),
        .o_rdata (meta_rd)
    );

    sals_set_update #(
        .WAYS   (WAYS),
        .TAG_W  (TAG_W),
        .RANK_W (RANK_W)
    ) u_update (
        .i_kind     (r_kind),
        .i_tag      (r_tag),
        .i_tag_row  (tag_rd),
        .i_meta_row (meta_rd),
        .o_rsp      (upd_rsp),
        .o_tag_row  (tag_wr),
        .o_tag_we   (tag_upd_we),
        .o_meta_row (meta_upd)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_req.kind;
            r_set  <= in_set;
            r_tag  <= in_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_busy    <= 1'b1;
            r_strobe  <= 1'b0;
            r_clr_idx <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= IDX_W'(r_clr_idx + 1'b1);
                    if (r_clr_idx == IDX_W'(SETS - 1)) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_LOOK;
                        r_busy  <= 1'b1;
                    end
                end
                S_LOOK: begin
                    r_state  <= S_IDLE;
                    r_busy   <= 1'b0;
                    r_strobe <= 1'b1;
                    r_rsp    <= upd_rsp;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    `SALS_ASSERT_NEXT(a_rsp_follows_req, i_clk, i_rst_n, start && !busy, !o_strobe ##1 o_strobe)
    `SALS_ASSERT_IMP(a_idle_with_rsp, i_clk, i_rst_n, o_strobe, !busy)
    `SALS_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_strobe, !o_strobe)
    `SALS_ASSERT_IMP(a_replace_is_miss, i_clk, i_rst_n, o_strobe && o_rsp.replaced, o_rsp.forward_miss && !o_rsp.hit)

endmodule

[sv/sals_ram.sv]
module sals_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sals_set_update.sv]
module sals_set_update #(
    parameter int WAYS   = 8,
    parameter int TAG_W  = 36,
    parameter int RANK_W = 3
) (
    input  logic                      i_kind,
    input  logic [TAG_W-1:0]          i_tag,
    input  logic [WAYS*TAG_W-1:0]     i_tag_row,
    input  logic [WAYS*(1+RANK_W)-1:0] i_meta_row,
    output sals_pkg::t_rsp            o_rsp,
    output logic [WAYS*TAG_W-1:0]     o_tag_row,
    output logic                      o_tag_we,
    output logic [WAYS*(1+RANK_W)-1:0] o_meta_row
);
    import sals_pkg::*;

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [RANK_W-1:0] OLDEST = RANK_W'(WAYS - 1);

    logic              v   [WAYS];
    logic [RANK_W-1:0] rk  [WAYS];
    logic [TAG_W-1:0]  tg  [WAYS];
    logic              nv  [WAYS];
    logic [RANK_W-1:0] nr  [WAYS];
    logic [TAG_W-1:0]  ntg [WAYS];
    logic              found, free;
    logic [WAY_W-1:0]  hway, fway, vway, w;
    logic [RANK_W-1:0] r;

    always_comb begin
        found = 1'b0;
        free  = 1'b0;
        hway  = '0;
        fway  = '0;
        vway  = '0;
        for (int j = 0; j < WAYS; j++) begin
            v[j]  = i_meta_row[j];
            rk[j] = i_meta_row[WAYS + j*RANK_W +: RANK_W];
            tg[j] = i_tag_row[j*TAG_W +: TAG_W];
        end
        // lowest-numbered way wins each search
        for (int j = WAYS - 1; j >= 0; j--) begin
            if (v[j] && tg[j] == i_tag) begin
                found = 1'b1;
                hway  = WAY_W'(j);
            end
            if (!v[j]) begin
                free = 1'b1;
                fway = WAY_W'(j);
            end
            // a full set holds every rank once, so the oldest has the top rank
            if (rk[j] == OLDEST) begin
                vway = WAY_W'(j);
            end
        end

        if (found) begin
            w = hway;
        end else if (i_kind == KIND_INVAL) begin
            w = '0;
        end else if (free) begin
            w = fway;
        end else begin
            w = vway;
        end
        r = rk[w];

        for (int j = 0; j < WAYS; j++) begin
            nv[j]  = v[j];
            nr[j]  = rk[j];
            ntg[j] = tg[j];
        end
        o_tag_we = 1'b0;

        if (i_kind == KIND_INVAL) begin
            if (found) begin
                for (int j = 0; j < WAYS; j++) begin
                    if (v[j] && rk[j] > r) begin
                        nr[j] = RANK_W'(rk[j] - 1'b1);
                    end
                end
                nv[w] = 1'b0;
                nr[w] = '0;
            end
        end else begin
            for (int j = 0; j < WAYS; j++) begin
                if (v[j] && (!found && free || rk[j] < r)) begin
                    nr[j] = RANK_W'(rk[j] + 1'b1);
                end
            end
            nr[w] = '0;
            if (!found) begin
                nv[w]    = 1'b1;
                ntg[w]   = i_tag;
                o_tag_we = 1'b1;
            end
        end

        for (int j = 0; j < WAYS; j++) begin
            o_meta_row[j]                          = nv[j];
            o_meta_row[WAYS + j*RANK_W +: RANK_W]  = nr[j];
            o_tag_row[j*TAG_W +: TAG_W]            = ntg[j];
        end

        o_rsp.hit          = found;
        o_rsp.forward_miss = (i_kind == KIND_ACCESS) && !found;
        o_rsp.way          = OUT_WAY_W'(w);
        o_rsp.replaced     = (i_kind == KIND_ACCESS) && !found && !free;
    end

endmodule

[tb/lru_tag_checker.sv]
module lru_tag_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  sals_pkg::t_req i_req,
    input  logic           i_strobe,
    input  sals_pkg::t_rsp i_rsp,
    output int             o_fail_count,
    output int             o_pending
);
    import sals_pkg::*;

    localparam int SETS  = SETS_DEF;
    localparam int WAYS  = WAYS_DEF;
    localparam int OFS_W = $clog2(LINE_BYTES_DEF);
    localparam int SET_W = $clog2(SETS_DEF);
    localparam int TAG_W = IN_ADDR_W - OFS_W - SET_W;
    localparam logic [IN_ADDR_W-1:0] ADDR_MASK = (ADDR_BITS_DEF >= IN_ADDR_W) ?
        {IN_ADDR_W{1'b1}} : ((IN_ADDR_W'(1) << ADDR_BITS_DEF) - 1'b1);

    logic             line_valid [SETS][WAYS];
    logic [TAG_W-1:0] line_tag   [SETS][WAYS];
    int unsigned      line_age   [SETS][WAYS];
    t_rsp             expected_rsp [$];

    // make way w the newest; valid ways newer than its old age get one older
    function automatic void promote(input int unsigned s, input int unsigned w,
                                    input int unsigned old_age);
        for (int j = 0; j < WAYS; j++) begin
            if (j != w && line_valid[s][j] && line_age[s][j] < old_age)
                line_age[s][j]++;
        end
        line_age[s][w] = 0;
    endfunction

    function automatic t_rsp apply_request(input t_req req);
        logic [IN_ADDR_W-1:0] line;
        logic [TAG_W-1:0]     tg;
        int unsigned          s;
        int unsigned          w;
        int unsigned          age;
        int unsigned          oldest;
        bit                   found;
        bit                   free_found;
        t_rsp                 r;
        line  = (req.address & ADDR_MASK) >> OFS_W;
        s     = int'(line % SETS);
        tg    = TAG_W'(line >> SET_W);
        r     = '0;
        w     = 0;
        found = 1'b0;
        for (int j = 0; j < WAYS; j++) begin
            if (!found && line_valid[s][j] && line_tag[s][j] == tg) begin
                found = 1'b1;
                w     = j;
            end
        end
        if (req.kind == KIND_INVAL) begin
            if (found) begin
                age = line_age[s][w];
                for (int j = 0; j < WAYS; j++) begin
                    if (j != w && line_valid[s][j] && line_age[s][j] > age)
                        line_age[s][j]--;
                end
                line_valid[s][w] = 1'b0;
                line_age[s][w]   = 0;
                r.hit            = 1'b1;
            end else begin
                w = 0;
            end
        end else if (found) begin
            r.hit = 1'b1;
            promote(s, w, line_age[s][w]);
        end else begin
            r.forward_miss = 1'b1;
            free_found     = 1'b0;
            for (int j = 0; j < WAYS; j++) begin
                if (!free_found && !line_valid[s][j]) begin
                    free_found = 1'b1;
                    w          = j;
                end
            end
            if (free_found) begin
                for (int j = 0; j < WAYS; j++) begin
                    if (line_valid[s][j] && line_age[s][j] < 255)
                        line_age[s][j]++;
                end
                line_age[s][w] = 0;
            end else begin
                oldest = 0;
                w      = 0;
                for (int j = 0; j < WAYS; j++) begin
                    if (j == 0 || line_age[s][j] > oldest) begin
                        oldest = line_age[s][j];
                        w      = j;
                    end
                end
                r.replaced = 1'b1;
                promote(s, w, oldest);
            end
            line_valid[s][w] = 1'b1;
            line_tag[s][w]   = tg;
        end
        r.way = w[OUT_WAY_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        bit   taken;
        bit   given;
        taken = i_rst_n && i_start && !i_busy;
        given = i_rst_n && i_strobe;
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                for (int w = 0; w < WAYS; w++) begin
                    line_valid[s][w] = 1'b0;
                    line_age[s][w]   = 0;
                end
            end
            expected_rsp.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (given) begin
                if (expected_rsp.size() == 0) begin
                    $error("result with no transaction outstanding: %p", i_rsp);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_rsp.pop_front();
                    if (i_rsp !== want) begin
                        if (i_rsp.hit !== want.hit)
                            $error("hit: expected %0d, got %0d", want.hit, i_rsp.hit);
                        if (i_rsp.forward_miss !== want.forward_miss)
                            $error("forward_miss: expected %0d, got %0d",
                                   want.forward_miss, i_rsp.forward_miss);
                        if (i_rsp.way !== want.way)
                            $error("way: expected %0d, got %0d", want.way, i_rsp.way);
                        if (i_rsp.replaced !== want.replaced)
                            $error("replaced: expected %0d, got %0d",
                                   want.replaced, i_rsp.replaced);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (taken)
                expected_rsp.push_back(apply_request(i_req));
            o_pending <= expected_rsp.size();
        end
    end

endmodule

[tb/tb_set_assoc_lru_tag_store_unit.sv]
module tb_set_assoc_lru_tag_store_unit;
    import sals_pkg::*;

    localparam int OFS_W        = $clog2(LINE_BYTES_DEF);
    localparam int SET_W        = $clog2(SETS_DEF);
    localparam int TAG_W        = IN_ADDR_W - OFS_W - SET_W;
    localparam int RANDOM_ITEMS = 1150;
    localparam int TAG_POOL     = 12;
    localparam int HOT_SETS     = 4;
    localparam int IDLE_LIMIT   = 1000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req req     = '0;
    logic busy;
    logic o_strobe;
    t_rsp rsp;
    int   fail_count;
    int   pending_count;
    int   idle_cycles = 0;

    logic [TAG_W-1:0] tag_pool [TAG_POOL];
    logic [SET_W-1:0] hot_set  [HOT_SETS];

    always #5 i_clk = ~i_clk;

    set_assoc_lru_tag_store_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_rsp    (rsp)
    );

    lru_tag_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_strobe     (o_strobe),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [IN_ADDR_W-1:0] line_address(input logic [TAG_W-1:0] tg,
                                                         input logic [SET_W-1:0] s,
                                                         input logic [OFS_W-1:0] ofs);
        return {tg, s, ofs};
    endfunction

    // returns at the edge where the transaction is taken; start stays high
    task automatic issue_request(input logic kind, input logic [IN_ADDR_W-1:0] addr);
        start         <= 1'b1;
        req.kind      <= kind;
        req.address   <= addr;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    task automatic pick_hot_sets();
        for (int k = 0; k < HOT_SETS; k++) hot_set[k] = SET_W'($urandom);
    endtask

    task automatic random_request();
        logic                 kind;
        logic [IN_ADDR_W-1:0] addr;
        kind = ($urandom_range(0, 4) == 0) ? KIND_INVAL : KIND_ACCESS;
        if ($urandom_range(0, 3) == 0) begin
            addr = IN_ADDR_W'({$urandom(), $urandom()});
        end else begin
            addr = line_address(tag_pool[$urandom_range(0, TAG_POOL - 1)],
                                hot_set[$urandom_range(0, HOT_SETS - 1)],
                                OFS_W'($urandom));
        end
        issue_request(kind, addr);
    endtask

    initial begin
        int sent;
        int burst;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue_request(KIND_ACCESS, '0);
        issue_request(KIND_ACCESS, '0);
        issue_request(KIND_INVAL, '0);
        issue_request(KIND_INVAL, '0);
        issue_request(KIND_ACCESS, '1);
        issue_request(KIND_ACCESS, line_address('1, '1, '0));
        issue_request(KIND_INVAL, '1);
        // fill every way of one set, then evict, touch and invalidate
        for (int t = 0; t < WAYS_DEF; t++)
            issue_request(KIND_ACCESS,
                          line_address(TAG_W'(t) | {1'b1, {TAG_W-1{1'b0}}}, SET_W'(5),
                                       OFS_W'($urandom)));
        issue_request(KIND_ACCESS, line_address(TAG_W'(100), SET_W'(5), OFS_W'(0)));
        issue_request(KIND_ACCESS, line_address(TAG_W'(1) | {1'b1, {TAG_W-1{1'b0}}},
                                                SET_W'(5), OFS_W'(7)));
        issue_request(KIND_INVAL, line_address(TAG_W'(3) | {1'b1, {TAG_W-1{1'b0}}},
                                               SET_W'(5), OFS_W'(9)));
        issue_request(KIND_ACCESS, line_address(TAG_W'(101), SET_W'(5), '1));
        issue_request(KIND_ACCESS, line_address(TAG_W'(102), SET_W'(5), OFS_W'(0)));
        issue_request(KIND_ACCESS, line_address(TAG_W'(1) | {1'b1, {TAG_W-1{1'b0}}},
                                                SET_W'(5), OFS_W'(0)));
        wait_for_results();

        for (int k = 0; k < TAG_POOL; k++) tag_pool[k] = TAG_W'({$urandom(), $urandom()});
        pick_hot_sets();
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                random_request();
                sent++;
            end
            if ($urandom_range(0, 15) == 0) begin
                wait_for_results();
                pick_hot_sets();
            end else if ($urandom_range(0, 9) >= 3) begin
                hold_off($urandom_range(1, 8));
            end
        end

        wait_for_results();
        repeat (4) @(posedge i_clk);
        if (pending_count != 0)
            $error("%0d transactions never produced a result", pending_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/sals_pkg.sv
sv/sals_ram.sv
sv/sals_set_update.sv
sv/set_assoc_lru_tag_store_unit.sv
tb/lru_tag_checker.sv
tb/tb_set_assoc_lru_tag_store_unit.sv
